### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro takes a label, the clock,
// the reset, a trigger condition and the property that must follow.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, clk_sig, rst_sig, trig, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (trig) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, trig, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (trig) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk_sig, rst_sig, trig, cons)
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, trig, cons)

`endif

`endif

### hw/rtl/ppsm_pkg.sv
package ppsm_pkg;

  // Port states, as reported on the output word.
  typedef enum logic [3:0] {
    ST_INIT     = 4'd0,
    ST_FAULTY   = 4'd1,
    ST_DISABLED = 4'd2,
    ST_LISTEN   = 4'd3,
    ST_PREMAST  = 4'd4,
    ST_MASTER   = 4'd5,
    ST_PASSIVE  = 4'd6,
    ST_UNCAL    = 4'd7,
    ST_SLAVE    = 4'd8,
    ST_GRAND    = 4'd9
  } role_state_t;

  // Event codes. Code 15 carries no meaning and acts like EV_OTHER.
  typedef enum logic [3:0] {
    EV_INIT     = 4'd0,
    EV_PWRUP    = 4'd1,
    EV_DISABLE  = 4'd2,
    EV_ENABLE   = 4'd3,
    EV_FCLEAR   = 4'd4,
    EV_FDETECT  = 4'd5,
    EV_ANNTO    = 4'd6,
    EV_RSMAST   = 4'd7,
    EV_RSGRAND  = 4'd8,
    EV_RSSLAVE  = 4'd9,
    EV_RSPASS   = 4'd10,
    EV_QUALTO   = 4'd11,
    EV_MSEL     = 4'd12,
    EV_SYNCF    = 4'd13,
    EV_OTHER    = 4'd14
  } ptp_event_t;

  localparam int unsigned DataInW  = 8;
  localparam int unsigned DataOutW = 8;

  // Next port state for one event, under either transition table.
  function automatic role_state_t next_state(role_state_t cur, ptp_event_t ev,
                                             logic chg, logic slave_only);
    role_state_t nxt;
    nxt = cur;
    if (ev inside {EV_INIT, EV_PWRUP}) begin
      nxt = ST_INIT;
    end else if (cur == ST_INIT) begin
      nxt = ST_LISTEN;
    end else if (cur == ST_FAULTY) begin
      if (ev == EV_DISABLE) begin
        nxt = ST_DISABLED;
      end else if (ev == EV_FCLEAR) begin
        nxt = ST_INIT;
      end
    end else if (cur == ST_DISABLED) begin
      if (ev == EV_ENABLE) begin
        nxt = ST_INIT;
      end
    end else if (slave_only) begin
      // Slave-only table: master roles are never entered, and a port already
      // in one stays there until an init or power-up event.
      if (cur inside {ST_LISTEN, ST_UNCAL, ST_SLAVE}) begin
        case (ev)
          EV_DISABLE: nxt = ST_DISABLED;
          EV_FDETECT: nxt = ST_FAULTY;
          EV_ANNTO, EV_RSMAST, EV_RSGRAND, EV_RSPASS: nxt = ST_LISTEN;
          EV_RSSLAVE: begin
            if (cur == ST_LISTEN || (cur == ST_SLAVE && chg)) begin
              nxt = ST_UNCAL;
            end
          end
          EV_MSEL: begin
            if (cur == ST_UNCAL) begin
              nxt = ST_SLAVE;
            end
          end
          EV_SYNCF: begin
            if (cur == ST_SLAVE) begin
              nxt = ST_UNCAL;
            end
          end
          default: nxt = cur;
        endcase
      end
    end else if (ev == EV_DISABLE) begin
      nxt = ST_DISABLED;
    end else if (ev == EV_FDETECT) begin
      nxt = ST_FAULTY;
    end else begin
      // Full table, active states.
      case (cur)
        ST_LISTEN, ST_PASSIVE, ST_UNCAL, ST_SLAVE: begin
          case (ev)
            EV_ANNTO:   nxt = ST_MASTER;
            EV_RSMAST:  nxt = ST_PREMAST;
            EV_RSGRAND: nxt = ST_GRAND;
            EV_RSPASS:  nxt = ST_PASSIVE;
            EV_RSSLAVE: begin
              if (cur != ST_SLAVE || chg) begin
                nxt = ST_UNCAL;
              end
            end
            EV_MSEL: begin
              if (cur == ST_UNCAL) begin
                nxt = ST_SLAVE;
              end
            end
            EV_SYNCF: begin
              if (cur == ST_SLAVE) begin
                nxt = ST_UNCAL;
              end
            end
            default: nxt = cur;
          endcase
        end
        ST_PREMAST: begin
          case (ev)
            EV_QUALTO:  nxt = ST_MASTER;
            EV_RSSLAVE: nxt = ST_UNCAL;
            EV_RSPASS:  nxt = ST_PASSIVE;
            default:    nxt = cur;
          endcase
        end
        ST_MASTER, ST_GRAND: begin
          case (ev)
            EV_RSSLAVE: nxt = ST_UNCAL;
            EV_RSPASS:  nxt = ST_PASSIVE;
            default:    nxt = cur;
          endcase
        end
        default: nxt = cur;
      endcase
    end
    return nxt;
  endfunction

endpackage

### hw/rtl/ptp_port_state_machine_unit.sv
// Channel   Direction  Handshake                     Word contents
// s_axis    in         s_axis_tvalid/s_axis_tready   event_code, master_changed
// m_axis    out        m_axis_tvalid/m_axis_tready   new_state
// cfg       in         cfg_wr_en                     slave_only_mode
//
// One word is taken per clock unless m_axis stalls; its new state appears on
// m_axis in the cycle after acceptance, set by the single next-state lookup.
// A new word is accepted while the output register is empty or being drained.
// Reset puts the port in initializing and selects the full transition table.
// A stall on m_axis holds the result and blocks input only while it lasts.
`include "assert_macros.svh"

module ptp_port_state_machine_unit
  import ppsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DataInW-1:0]  s_axis_tdata,   // [3:0] event_code, [4] master_changed
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DataOutW-1:0] m_axis_tdata    // [3:0] new_state
);

  logic        slave_only_mode;
  role_state_t port_role_state;
  role_state_t state_next;
  role_state_t out_state;
  logic        in_accept;

  // Input is taken whenever the result register is free or being taken.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Next-state lookup for the incoming word.
  assign state_next = next_state(port_role_state, ptp_event_t'(s_axis_tdata[3:0]),
                                 s_axis_tdata[4], slave_only_mode);

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_only_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      slave_only_mode <= cfg_wr_data;
    end
  end

  // Port state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      port_role_state <= ST_INIT;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (in_accept) begin
        port_role_state <= state_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_state <= state_next;
    end
  end

  assign m_axis_tdata = {{(DataOutW-4){1'b0}}, out_state};

  // Init and power-up always land in initializing with a result pending.
  `ASSERT_NEXT(a_init_event, clk, rst,
    in_accept && (s_axis_tdata[3:0] == EV_INIT || s_axis_tdata[3:0] == EV_PWRUP),
    port_role_state == ST_INIT && m_axis_tvalid)

  // The reported state is the state just entered.
  `ASSERT_NEXT(a_out_matches_state, clk, rst, in_accept, out_state == port_role_state)

  // Under the slave-only table a non-master state never moves into a master role.
  `ASSERT_NEXT(a_slave_only_no_master, clk, rst,
    in_accept && slave_only_mode && !cfg_wr_en &&
      (port_role_state == ST_LISTEN || port_role_state == ST_UNCAL ||
       port_role_state == ST_SLAVE),
    port_role_state != ST_PREMAST && port_role_state != ST_MASTER &&
      port_role_state != ST_GRAND)

  // Input readiness follows the result register occupancy.
  `ASSERT_SAME(a_ready_rule, clk, rst, 1'b1,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // Without an accepted word the port state does not move.
  `ASSERT_NEXT(a_state_holds, clk, rst, !in_accept, $stable(port_role_state))

endmodule
